### sv/slcd_pkg.sv
// Shared constants, types and text tables for the serial line command decoder.
package slcd_pkg;

    localparam int LINE_CHARS = 32;
    localparam int LINE_AW    = $clog2(LINE_CHARS);
    localparam int LINE_LW    = $clog2(LINE_CHARS + 1);

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [3:0] STAT_LAST = 4'd9;
    localparam logic [3:0] TOG_LAST  = 4'd14;

    typedef struct packed {
        logic [LINE_LW-1:0] len;
        logic               is_status;
        logic               is_toggle;
        logic               has_set;
        logic               num_nz;
    } t_scan_res;

    function automatic logic [7:0] status_chr(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "s";
            3'd1:    c = "t";
            3'd2:    c = "a";
            3'd3:    c = "t";
            3'd4:    c = "u";
            3'd5:    c = "s";
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] toggle_chr(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "t";
            3'd1:    c = "o";
            3'd2:    c = "g";
            3'd3:    c = "g";
            3'd4:    c = "l";
            3'd5:    c = "e";
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] stat_reply_chr(input logic [3:0] idx, input logic relay);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "S";
            4'd1:    c = "t";
            4'd2:    c = "a";
            4'd3:    c = "t";
            4'd4:    c = "u";
            4'd5:    c = "s";
            4'd6:    c = ":";
            4'd7:    c = CHAR_SPACE;
            4'd8:    c = CHAR_ZERO | {7'd0, relay};
            4'd9:    c = CHAR_LF;
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] tog_reply_chr(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "T";
            4'd1:    c = "o";
            4'd2:    c = "g";
            4'd3:    c = "g";
            4'd4:    c = "e";
            4'd5:    c = "l";
            4'd6:    c = "i";
            4'd7:    c = "n";
            4'd8:    c = "g";
            4'd9:    c = CHAR_SPACE;
            4'd10:   c = "G";
            4'd11:   c = "P";
            4'd12:   c = "I";
            4'd13:   c = "O";
            4'd14:   c = CHAR_LF;
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

endpackage

### sv/slcd_line_ram.sv
// Line store: simple dual-port RAM with a registered read port.
module slcd_line_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/slcd_cmd_scan.sv
// Command scanner: walks the stored line one byte a cycle and collects match flags.
module slcd_cmd_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clr,
    input  logic                         i_vld,
    input  logic [7:0]                   i_byte,
    input  logic [slcd_pkg::LINE_AW-1:0] i_idx,
    output slcd_pkg::t_scan_res          o_res
);
    import slcd_pkg::*;

    typedef enum logic [1:0] {NP_PRE, NP_WS, NP_DIG, NP_END} t_np;

    logic               r_zero;
    logic [LINE_LW-1:0] r_len;
    logic               r_st_ok;
    logic               r_tg_ok;
    logic [7:0]         r_p0, r_p1, r_p2;
    logic               r_set;
    t_np                r_np;
    logic               r_nz;

    logic is_space, is_digit, is_sign, in_word;

    assign is_space = (i_byte == CHAR_SPACE) || (i_byte >= 8'd9 && i_byte <= CHAR_CR);
    assign is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign is_sign  = (i_byte == CHAR_PLUS) || (i_byte == CHAR_MINUS);
    assign in_word  = (i_idx < LINE_AW'(6));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_zero  <= 1'b0;
            r_len   <= '0;
            r_st_ok <= 1'b1;
            r_tg_ok <= 1'b1;
            r_p0    <= CHAR_NUL;
            r_p1    <= CHAR_NUL;
            r_p2    <= CHAR_NUL;
            r_set   <= 1'b0;
            r_np    <= NP_PRE;
            r_nz    <= 1'b0;
        end else if (i_vld && !r_zero) begin
            if (i_byte == CHAR_NUL) begin
                // text ends at the first zero byte
                r_zero <= 1'b1;
            end else begin
                r_len   <= LINE_LW'(i_idx) + LINE_LW'(1);
                r_st_ok <= r_st_ok && in_word && (i_byte == status_chr(i_idx[2:0]));
                r_tg_ok <= r_tg_ok && in_word && (i_byte == toggle_chr(i_idx[2:0]));
                r_p0    <= i_byte;
                r_p1    <= r_p0;
                r_p2    <= r_p1;
                if (i_byte == CHAR_EQ && r_p0 == "t" && r_p1 == "e" && r_p2 == "s") begin
                    r_set <= 1'b1;
                end
                unique case (r_np)
                    NP_PRE: begin
                        if (i_byte == CHAR_EQ) r_np <= NP_WS;
                    end
                    NP_WS: begin
                        if (is_space) begin
                            r_np <= NP_WS;
                        end else if (is_sign) begin
                            r_np <= NP_DIG;
                        end else if (is_digit) begin
                            r_np <= NP_DIG;
                            if (i_byte != CHAR_ZERO) r_nz <= 1'b1;
                        end else begin
                            r_np <= NP_END;
                        end
                    end
                    NP_DIG: begin
                        if (is_digit) begin
                            if (i_byte != CHAR_ZERO) r_nz <= 1'b1;
                        end else begin
                            r_np <= NP_END;
                        end
                    end
                    NP_END: r_np <= NP_END;
                    default: r_np <= NP_END;
                endcase
            end
        end
    end

    always_comb begin
        o_res.len       = r_len;
        o_res.is_status = r_st_ok && (r_len == LINE_LW'(6));
        o_res.is_toggle = r_tg_ok && (r_len == LINE_LW'(6));
        o_res.has_set   = r_set;
        o_res.num_nz    = r_nz;
    end

endmodule

### sv/serial_line_command_decoder_unit.sv
// Serial line command decoder: byte input, line store, command handling and reply output.
//
// Input stream (s_axis): one received byte per transaction in tdata[7:0]. Ordinary
// bytes are written to the line store and give no output. A full line (LINE_CHARS bytes)
// is dropped before the next byte is stored.
// A carriage return ends the line: the line store is read back one byte a cycle
// to find the text length, match "status" and "toggle", find "set=" and evaluate
// the number after the first '='. The relay bit is then updated and the reply is
// sent on the output stream (m_axis): reply text for "status" and "toggle" at one
// byte per cycle while the receiver is ready, then the echoed line, one line store
// read and one output load per byte. tlast marks the final byte of a line's reply;
// lines with no text give no output. tdata[8] carries the relay state after the line.
// The input is ready only while no line is being handled; the last reply byte may
// still wait in the output register when the next byte is accepted.
// A stalled receiver holds the output register and pauses the reply.
// Reset clears the line length, the relay bit and all control state; the line
// store itself is not cleared and needs no clearing pass.
module serial_line_command_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] tx_byte, [8] relay_on, [15:9] zero
    output logic        o_m_axis_tlast
);
    import slcd_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_TXT, S_ECHO_RD, S_ECHO_WR} t_state;

    t_state             r_state;
    logic               r_relay;
    logic [LINE_LW-1:0] r_line_len;
    logic [LINE_LW-1:0] r_addr;
    logic [LINE_AW-1:0] r_rd_idx;
    logic               r_rd_vld;
    logic [3:0]         r_ti;
    logic               r_out_vld;
    logic [7:0]         r_tx;
    logic               r_out_relay;
    logic               r_last;

    logic               in_acc, is_cr, out_free, scan_end;
    logic               we, re;
    logic [LINE_AW-1:0] waddr;
    logic [7:0]         rdata;
    logic [3:0]         txt_last;
    logic [7:0]         txt_byte;
    logic               echo_last;
    t_scan_res          res;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign is_cr     = (i_s_axis_tdata == CHAR_CR);
    assign out_free  = !r_out_vld || i_m_axis_tready;
    assign scan_end  = (r_state == S_SCAN) && (r_addr == r_line_len) && !r_rd_vld;

    // Drop a full line before storing the next byte
    assign we    = in_acc && !is_cr;
    assign waddr = (r_line_len == LINE_LW'(LINE_CHARS)) ? '0 : r_line_len[LINE_AW-1:0];
    assign re    = ((r_state == S_SCAN) && (r_addr != r_line_len)) || (r_state == S_ECHO_RD);

    assign txt_last  = res.is_status ? STAT_LAST : TOG_LAST;
    assign txt_byte  = res.is_status ? stat_reply_chr(r_ti, r_relay) : tog_reply_chr(r_ti);
    assign echo_last = ((r_addr + LINE_LW'(1)) == res.len);

    slcd_line_ram #(
        .DEPTH (LINE_CHARS),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_s_axis_tdata),
        .i_re    (re),
        .i_raddr (r_addr[LINE_AW-1:0]),
        .o_rdata (rdata)
    );

    slcd_cmd_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (in_acc && is_cr),
        .i_vld   (r_rd_vld),
        .i_byte  (rdata),
        .i_idx   (r_rd_idx),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_relay     <= 1'b0;
            r_line_len  <= '0;
            r_addr      <= '0;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_ti        <= '0;
            r_out_vld   <= 1'b0;
            r_tx        <= CHAR_NUL;
            r_out_relay <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_rd_vld <= 1'b0;
            if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (is_cr) begin
                            r_addr  <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_line_len <= LINE_LW'(waddr) + LINE_LW'(1);
                        end
                    end
                end
                S_SCAN: begin
                    if (re) begin
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_addr[LINE_AW-1:0];
                        r_addr   <= r_addr + LINE_LW'(1);
                    end
                    if (scan_end) begin
                        if (res.is_toggle) begin
                            r_relay <= !r_relay;
                        end else if (res.has_set) begin
                            r_relay <= res.num_nz;
                        end
                        r_line_len <= '0;
                        r_addr     <= '0;
                        r_ti       <= '0;
                        if (res.is_status || res.is_toggle) begin
                            r_state <= S_TXT;
                        end else if (res.len != '0) begin
                            r_state <= S_ECHO_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_TXT: begin
                    if (out_free) begin
                        r_out_vld   <= 1'b1;
                        r_tx        <= txt_byte;
                        r_out_relay <= r_relay;
                        r_last      <= (r_ti == txt_last) && (res.len == '0);
                        r_ti        <= r_ti + 4'd1;
                        if (r_ti == txt_last) begin
                            r_state <= (res.len == '0) ? S_IDLE : S_ECHO_RD;
                        end
                    end
                end
                S_ECHO_RD: begin
                    r_state <= S_ECHO_WR;
                end
                S_ECHO_WR: begin
                    // Read data holds until the next read, so wait here on a stall
                    if (out_free) begin
                        r_out_vld   <= 1'b1;
                        r_tx        <= rdata;
                        r_out_relay <= r_relay;
                        r_last      <= echo_last;
                        r_addr      <= r_addr + LINE_LW'(1);
                        r_state     <= echo_last ? S_IDLE : S_ECHO_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    // Relay state travels with its byte, so a waiting byte holds its value
    assign o_m_axis_tdata  = {7'd0, r_out_relay, r_tx};
    assign o_m_axis_tlast  = r_last;

`ifndef ASSERT_OFF
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_len <= LINE_LW'(LINE_CHARS))
        else $error("line length beyond line store depth");

    a_relay_at_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_relay != $past(r_relay)) |-> ($past(r_state) == S_SCAN))
        else $error("relay changed outside command handling");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("output transaction changed while stalled");

    a_cr_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_cr) |=> (r_state == S_SCAN))
        else $error("carriage return did not start the line scan");
`endif

endmodule
